[src/cfz_pkg.sv]
// Shared types and constants for the Cholesky factorization core.
package cfz_pkg;

   localparam int DATA_W = 32;
   localparam int IDX_W  = 2;
   localparam int WIDE_W = 64;

   typedef struct packed {
      logic start;
      logic sqrt_mode;
   } iter_cmd_type;

endpackage

[src/cholesky_factorization_core.sv]
// Top level of the Cholesky factorization core.
// Load: one element per cycle, DIM*(DIM+1)/2 transfers, ready held high meanwhile.
// Compute: per factor element, each inner product term is read, multiplied, subtracted,
// then square root or divide in the shared iterative unit; no input until emission ends.
// Emission: each result is read, registered and held until the output accepts it.
// Synchronous active-high reset clears control state; matrix memory is not cleared.
module cholesky_factorization_core #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [cfz_pkg::DATA_W-1:0]    req_tdata,  // entry_value
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [39:0]                   rsp_tdata,  // factor_value, row_index, col_index, pad
   output logic                          rsp_tuser,  // not_definite
   output logic                          rsp_tlast
);
   import cfz_pkg::*;

   localparam int TRI = (DIM * (DIM + 1)) / 2;
   localparam int AW  = (TRI > 1) ? $clog2(TRI) : 1;
   localparam int RW  = $clog2(DIM + 1);

   typedef enum logic [11:0] {
      ST_LOAD  = 12'b000000000001,
      ST_BASE  = 12'b000000000010,
      ST_BASEW = 12'b000000000100,
      ST_RDB   = 12'b000000001000,
      ST_RDA   = 12'b000000010000,
      ST_MUL   = 12'b000000100000,
      ST_SUB   = 12'b000001000000,
      ST_FIN   = 12'b000010000000,
      ST_WAIT  = 12'b000100000000,
      ST_ERD   = 12'b001000000000,
      ST_ELD   = 12'b010000000000,
      ST_EOUT  = 12'b100000000000
   } state_type;

   function automatic logic [AW-1:0] tri_pos(input int r, input int c);
      int t;
      t = r * DIM - (r * (r - 1)) / 2 + c - r;
      return AW'(t);
   endfunction

   state_type                 state_ff, state_in;
   logic [AW-1:0]             load_ff, load_in;
   logic [RW-1:0]             r_ff, r_in, c_ff, c_in, n_ff, n_in, frow_ff, frow_in;
   logic                      fault_ff, fault_in;
   logic signed [WIDE_W-1:0]  acc_ff, acc_in;
   logic signed [WIDE_W-1:0]  prod_ff;
   logic signed [DATA_W-1:0]  b_ff, b_in;
   logic [DATA_W-1:0]         piv_ff, piv_in;
   logic                      neg_ff, neg_in;
   logic [DATA_W-1:0]         mem [TRI];
   logic [DATA_W-1:0]         rdata_ff;
   logic [AW-1:0]             raddr, waddr;
   logic                      we;
   logic [DATA_W-1:0]         wdata;
   logic                      ovalid_ff, ovalid_in;
   logic [39:0]               odata_ff, odata_in;
   logic                      ouser_ff, ouser_in, olast_ff, olast_in;
   iter_cmd_type              cmd;
   logic [WIDE_W-1:0]         it_x, it_res;
   logic                      it_done;
   logic signed [WIDE_W-1:0]  sub_res;
   logic                      bad;
   logic [DATA_W-1:0]         qsat;

   cfz_iter u_iter (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .x_value (it_x),
      .divisor (piv_ff),
      .done    (it_done),
      .result  (it_res)
   );

   always_comb begin
      sub_res = acc_ff - prod_ff;
      if (acc_ff[63] != prod_ff[63] && sub_res[63] != acc_ff[63])
         sub_res = acc_ff[63] ? {1'b1, {(WIDE_W-1){1'b0}}} : {1'b0, {(WIDE_W-1){1'b1}}};
   end

   always_comb begin
      if (neg_ff)
         qsat = (it_res > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~it_res[31:0] + 32'd1);
      else
         qsat = (it_res > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : it_res[31:0];
   end

   assign bad = fault_ff && (r_ff >= frow_ff);

   always_comb begin
      state_in  = state_ff;
      load_in   = load_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      n_in      = n_ff;
      frow_in   = frow_ff;
      fault_in  = fault_ff;
      acc_in    = acc_ff;
      b_in      = b_ff;
      piv_in    = piv_ff;
      neg_in    = neg_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      ouser_in  = ouser_ff;
      olast_in  = olast_ff;
      raddr     = tri_pos(int'(r_ff), int'(c_ff));
      waddr     = tri_pos(int'(r_ff), int'(c_ff));
      wdata     = req_tdata;
      we        = 1'b0;
      cmd       = '0;
      it_x      = acc_ff;
      case (state_ff)
         ST_LOAD: begin
            waddr = load_ff;
            if (req_tvalid) begin
               we = 1'b1;
               if (int'(load_ff) == TRI - 1) begin
                  load_in  = '0;
                  r_in     = '0;
                  c_in     = '0;
                  fault_in = 1'b0;
                  state_in = ST_BASE;
               end else begin
                  load_in = load_ff + AW'(1);
               end
            end
         end
         ST_BASE: state_in = ST_BASEW;
         ST_BASEW: begin
            acc_in   = WIDE_W'($signed(rdata_ff)) <<< FRAC_BITS;
            n_in     = '0;
            state_in = (r_ff != '0) ? ST_RDB : ST_FIN;
         end
         ST_RDB: begin
            raddr    = tri_pos(int'(n_ff), int'(r_ff));
            state_in = ST_RDA;
         end
         ST_RDA: begin
            b_in     = $signed(rdata_ff);
            raddr    = tri_pos(int'(n_ff), int'(c_ff));
            state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_SUB;
         ST_SUB: begin
            acc_in   = sub_res;
            n_in     = n_ff + RW'(1);
            state_in = (n_ff + RW'(1) < r_ff) ? ST_RDB : ST_FIN;
         end
         ST_FIN: begin
            if (c_ff == r_ff) begin
               if (acc_ff[63] || acc_ff == '0) begin
                  fault_in = 1'b1;
                  frow_in  = r_ff;
                  r_in     = '0;
                  c_in     = '0;
                  state_in = ST_ERD;
               end else begin
                  cmd.start     = 1'b1;
                  cmd.sqrt_mode = 1'b1;
                  state_in      = ST_WAIT;
               end
            end else begin
               neg_in        = acc_ff[63];
               it_x          = acc_ff[63] ? (~acc_ff + 64'd1) : acc_ff;
               cmd.start     = 1'b1;
               cmd.sqrt_mode = 1'b0;
               state_in      = ST_WAIT;
            end
         end
         ST_WAIT: begin
            if (it_done) begin
               we = 1'b1;
               if (c_ff == r_ff) begin
                  wdata  = it_res[31] ? 32'h7FFF_FFFF : it_res[31:0];
                  piv_in = wdata;
               end else begin
                  wdata = qsat;
               end
               if (int'(c_ff) + 1 < DIM) begin
                  c_in     = c_ff + RW'(1);
                  state_in = ST_BASE;
               end else if (int'(r_ff) + 1 < DIM) begin
                  r_in     = r_ff + RW'(1);
                  c_in     = r_ff + RW'(1);
                  state_in = ST_BASE;
               end else begin
                  r_in     = '0;
                  c_in     = '0;
                  state_in = ST_ERD;
               end
            end
         end
         ST_ERD: state_in = ST_ELD;
         ST_ELD: begin
            ovalid_in = 1'b1;
            odata_in  = {4'b0, IDX_W'(c_ff), IDX_W'(r_ff), bad ? 32'd0 : rdata_ff};
            ouser_in  = bad;
            olast_in  = (int'(r_ff) == DIM - 1);
            state_in  = ST_EOUT;
         end
         ST_EOUT: begin
            if (rsp_tready) begin
               ovalid_in = 1'b0;
               if (int'(c_ff) + 1 < DIM) begin
                  c_in     = c_ff + RW'(1);
                  state_in = ST_ERD;
               end else if (int'(r_ff) + 1 < DIM) begin
                  r_in     = r_ff + RW'(1);
                  c_in     = r_ff + RW'(1);
                  state_in = ST_ERD;
               end else begin
                  fault_in = 1'b0;
                  state_in = ST_LOAD;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we)
         mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      c_ff     <= c_in;
      n_ff     <= n_in;
      frow_ff  <= frow_in;
      acc_ff   <= acc_in;
      b_ff     <= b_in;
      piv_ff   <= piv_in;
      neg_ff   <= neg_in;
      prod_ff  <= $signed(rdata_ff) * b_ff;
      odata_ff <= odata_in;
      ouser_ff <= ouser_in;
      olast_ff <= olast_in;
      if (reset) begin
         state_ff  <= ST_LOAD;
         load_ff   <= '0;
         fault_ff  <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         load_ff   <= load_in;
         fault_ff  <= fault_in;
         ovalid_ff <= ovalid_in;
      end
   end

   assign req_tready = (state_ff == ST_LOAD);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;
   assign rsp_tuser  = ouser_ff;
   assign rsp_tlast  = olast_ff;

endmodule

[src/cfz_iter.sv]
// Shared iterative unit: restoring square root or unsigned division, one bit per cycle.
module cfz_iter (
   input  logic                         clock,
   input  logic                         reset,
   input  cfz_pkg::iter_cmd_type        cmd,
   input  logic [cfz_pkg::WIDE_W-1:0]   x_value,
   input  logic [cfz_pkg::DATA_W-1:0]   divisor,
   output logic                         done,
   output logic [cfz_pkg::WIDE_W-1:0]   result
);
   import cfz_pkg::*;

   logic [WIDE_W-1:0] x_ff, x_in;
   logic [34:0]       rem_ff, rem_in;
   logic [31:0]       root_ff, root_in;
   logic [31:0]       div_ff;
   logic [5:0]        cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              mode_ff;
   logic [34:0]       shifted, trial, diff;
   logic              ge;

   always_comb begin
      shifted = mode_ff ? {rem_ff[32:0], x_ff[63:62]} : {rem_ff[33:0], x_ff[63]};
      trial   = mode_ff ? {1'b0, root_ff, 2'b01} : {3'b0, div_ff};
      diff    = shifted - trial;
      ge      = (shifted >= trial);
   end

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         x_in    = x_value;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff : shifted;
         if (mode_ff) begin
            x_in    = {x_ff[61:0], 2'b00};
            root_in = {root_ff[30:0], ge};
         end else begin
            x_in = {x_ff[62:0], ge};
         end
         cnt_in = cnt_ff + 6'd1;
         if ((mode_ff && cnt_ff == 6'd31) || (!mode_ff && cnt_ff == 6'd63)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (cmd.start) begin
         mode_ff <= cmd.sqrt_mode;
         div_ff  <= divisor;
      end
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done   = done_ff;
   assign result = mode_ff ? {32'b0, root_ff} : x_ff;

endmodule

[src/cfz_checker.sv]
// Port-level assertions for the Cholesky factorization core, bound to the top level.
module cfz_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   import cfz_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("loading while emitting");

   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid && req_tready)
      else $error("run did not end after last transfer");

   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[DATA_W-1:0] == '0)
      else $error("not definite entry carries a value");

endmodule

bind cholesky_factorization_core cfz_checker u_cfz_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
